/* sv/qsb_pkg.sv */
// shared constants, command and status types for the quicksort block sorter
`default_nettype none
package qsb_pkg;

  localparam int SET_SIZE_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int VALUE_W           = 32;

  // read address source of the element store
  typedef enum logic [2:0] {
    RD_HIGH,
    RD_J,
    RD_SLOT,
    RD_STK,
    RD_K
  } rd_sel_t;

  // write address and data source of the element store
  typedef enum logic [2:0] {
    WR_LOAD,
    WR_J_RD,
    WR_SLOT_VALJ,
    WR_HIGH_RD,
    WR_SLOT_PIV
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    st_we;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
    logic    pivot_ld;
    logic    valj_ld;
    logic    j_inc;
    logic    slot_inc;
    logic    push_l;
    logic    push_r;
    logic    pop;
    logic    pop_ld;
    logic    emit_ld;
    logic    k_inc;
  } cmd_t;

  typedef struct packed {
    logic in_done;
    logic single;
    logic j_at_high;
    logic le;
    logic slot_eq_j;
    logic push_l_ok;
    logic push_r_ok;
    logic sp_empty;
    logic out_free;
    logic k_last;
  } status_t;

endpackage
`default_nettype wire

/* sv/quicksort_block_sorter.sv */
// top level of the quicksort block sorter
//
//  channel  handshake             payload
//  input    in_valid / in_stall   value[31:0] signed, last
//  output   out_valid / out_stall value_res[31:0] signed, last_res
//
// load takes one item per cycle while in_valid is high; an item marked last, or the SET_SIZE-th, starts the sort.
// each partition step reads and compares every element, with two extra writes when a swap is needed,
// plus pivot, exchange and stack states per range, all set by the single read port of the element store ram.
// emit reads each item, then loads it into the output register; the next set loads while the final item waits.
// reset clears control state only; no clearing pass. a stalled output holds its item.
`default_nettype none
module quicksort_block_sorter #(
  parameter int SET_SIZE      = qsb_pkg::SET_SIZE_DEF,
  parameter int ELEMENT_WIDTH = qsb_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic signed [qsb_pkg::VALUE_W-1:0] value,
  input  wire logic                               last,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic signed [qsb_pkg::VALUE_W-1:0] value_res,
  output      logic                               last_res
);
  import qsb_pkg::*;

  cmd_t    cmd;
  status_t st;

  qsb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  qsb_dp #(
    .SET_SIZE     (SET_SIZE),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .last     (last),
    .value_res(value_res),
    .last_res (last_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire

/* sv/qsb_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none
module qsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/qsb_ctrl.sv */
// sequencing state machine for load, partition, range stack and emit
`default_nettype none
module qsb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire qsb_pkg::status_t st,
  output      qsb_pkg::cmd_t    cmd
);
  import qsb_pkg::*;

  typedef enum logic [15:0] {
    S_LOAD    = 16'b0000_0000_0000_0001,
    S_PIV_RD  = 16'b0000_0000_0000_0010,
    S_PIV_LD  = 16'b0000_0000_0000_0100,
    S_SCAN    = 16'b0000_0000_0000_1000,
    S_CMP     = 16'b0000_0000_0001_0000,
    S_SWP_W1  = 16'b0000_0000_0010_0000,
    S_SWP_W2  = 16'b0000_0000_0100_0000,
    S_FX_W1   = 16'b0000_0000_1000_0000,
    S_FX_W2   = 16'b0000_0001_0000_0000,
    S_PUSH_L  = 16'b0000_0010_0000_0000,
    S_PUSH_R  = 16'b0000_0100_0000_0000,
    S_POP     = 16'b0000_1000_0000_0000,
    S_POP_LD  = 16'b0001_0000_0000_0000,
    S_EMIT_RD = 16'b0010_0000_0000_0000,
    S_EMIT_LD = 16'b0100_0000_0000_0000,
    S_SPARE   = 16'b1000_0000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel = WR_LOAD;
    cmd.rd_sel = RD_K;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.st_we     = 1'b1;
          cmd.wr_sel    = WR_LOAD;
          if (st.in_done) begin
            state_next = st.single ? S_EMIT_RD : S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        cmd.rd_sel = RD_HIGH;
        state_next = S_PIV_LD;
      end
      S_PIV_LD: begin
        cmd.pivot_ld = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (st.j_at_high) begin
          // final exchange of the pivot into its slot
          cmd.rd_sel = RD_SLOT;
          state_next = S_FX_W1;
        end else begin
          cmd.rd_sel = RD_J;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.valj_ld = 1'b1;
        if (st.le && st.slot_eq_j) begin
          cmd.slot_inc = 1'b1;
          cmd.j_inc    = 1'b1;
          state_next   = S_SCAN;
        end else if (st.le) begin
          cmd.rd_sel = RD_SLOT;
          state_next = S_SWP_W1;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SWP_W1: begin
        cmd.st_we  = 1'b1;
        cmd.wr_sel = WR_J_RD;
        state_next = S_SWP_W2;
      end
      S_SWP_W2: begin
        cmd.st_we    = 1'b1;
        cmd.wr_sel   = WR_SLOT_VALJ;
        cmd.slot_inc = 1'b1;
        cmd.j_inc    = 1'b1;
        state_next   = S_SCAN;
      end
      S_FX_W1: begin
        cmd.st_we  = 1'b1;
        cmd.wr_sel = WR_HIGH_RD;
        state_next = S_FX_W2;
      end
      S_FX_W2: begin
        cmd.st_we  = 1'b1;
        cmd.wr_sel = WR_SLOT_PIV;
        state_next = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_l = st.push_l_ok;
        state_next = S_PUSH_R;
      end
      S_PUSH_R: begin
        cmd.push_r = st.push_r_ok;
        state_next = S_POP;
      end
      S_POP: begin
        if (st.sp_empty) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POP_LD;
        end
      end
      S_POP_LD: begin
        // pivot read goes straight from the popped range
        cmd.pop_ld = 1'b1;
        cmd.rd_sel = RD_STK;
        state_next = S_PIV_LD;
      end
      S_EMIT_RD: begin
        if (st.out_free) begin
          cmd.rd_sel = RD_K;
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (st.k_last) begin
          state_next = S_LOAD;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/qsb_dp.sv */
// datapath: element store, range stack, partition indexes and output register
`default_nettype none
module qsb_dp #(
  parameter int SET_SIZE      = qsb_pkg::SET_SIZE_DEF,
  parameter int ELEMENT_WIDTH = qsb_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic signed [qsb_pkg::VALUE_W-1:0] value,
  input  wire logic                               last,
  output      logic signed [qsb_pkg::VALUE_W-1:0] value_res,
  output      logic                               last_res,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire qsb_pkg::cmd_t                      cmd,
  output      qsb_pkg::status_t                   st
);
  import qsb_pkg::*;

  localparam int EW     = ELEMENT_WIDTH;
  localparam int IW     = $clog2(SET_SIZE);
  localparam int CW     = $clog2(SET_SIZE + 1);
  // pending ranges are disjoint and hold two or more elements each
  localparam int SDEPTH = (SET_SIZE / 2 < 2) ? 2 : SET_SIZE / 2;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int SPW    = $clog2(SDEPTH + 1);

  logic [CW-1:0]  cnt;
  logic [IW-1:0]  n_m1, low, high, slot, j, k;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_dec;
  logic [EW-1:0]  pivot, valj;

  logic           st_we;
  logic [IW-1:0]  st_waddr, st_raddr;
  logic [EW-1:0]  st_wdata, st_rdata;

  logic           stk_we;
  logic [2*IW-1:0] stk_wdata, stk_rdata;
  logic [IW-1:0]  stk_lo, stk_hi;

  assign sp_dec = sp - SPW'(1);
  assign stk_lo = stk_rdata[2*IW-1:IW];
  assign stk_hi = stk_rdata[IW-1:0];

  // store ports
  always_comb begin
    st_we    = cmd.st_we;
    st_waddr = cnt[IW-1:0];
    st_wdata = EW'($unsigned(value));
    case (cmd.wr_sel)
      WR_LOAD: begin
        st_waddr = cnt[IW-1:0];
        st_wdata = EW'($unsigned(value));
      end
      WR_J_RD: begin
        st_waddr = j;
        st_wdata = st_rdata;
      end
      WR_SLOT_VALJ: begin
        st_waddr = slot;
        st_wdata = valj;
      end
      WR_HIGH_RD: begin
        st_waddr = high;
        st_wdata = st_rdata;
      end
      WR_SLOT_PIV: begin
        st_waddr = slot;
        st_wdata = pivot;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
    case (cmd.rd_sel)
      RD_HIGH: st_raddr = high;
      RD_J:    st_raddr = j;
      RD_SLOT: st_raddr = slot;
      RD_STK:  st_raddr = stk_hi;
      RD_K:    st_raddr = k;
      default: st_raddr = k;
    endcase
  end

  qsb_ram #(
    .WIDTH(EW),
    .DEPTH(SET_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  // range stack, one entry per {low, high} pair
  assign stk_we    = cmd.push_l | cmd.push_r;
  assign stk_wdata = cmd.push_l ? {low, slot - IW'(1)} : {slot + IW'(1), high};

  qsb_ram #(
    .WIDTH(2 * IW),
    .DEPTH(SDEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(sp[SAW-1:0]),
    .wdata(stk_wdata),
    .raddr(sp_dec[SAW-1:0]),
    .rdata(stk_rdata)
  );

  // status
  assign st.in_done   = last | (cnt == CW'(SET_SIZE - 1));
  assign st.single    = (cnt == '0);
  assign st.j_at_high = (j == high);
  assign st.le        = ($signed(st_rdata) <= $signed(pivot));
  assign st.slot_eq_j = (slot == j);
  assign st.push_l_ok = ({1'b0, slot} > ({1'b0, low} + (IW + 1)'(1)));
  assign st.push_r_ok = (({1'b0, slot} + (IW + 1)'(1)) < {1'b0, high});
  assign st.sp_empty  = (sp == '0);
  assign st.out_free  = ~out_valid | ~out_stall;
  assign st.k_last    = (k == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        if (st.in_done) begin
          cnt  <= '0;
          n_m1 <= cnt[IW-1:0];
          low  <= '0;
          high <= cnt[IW-1:0];
          slot <= '0;
          j    <= '0;
          k    <= '0;
          sp   <= '0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      if (cmd.pivot_ld) begin
        pivot <= st_rdata;
      end
      if (cmd.valj_ld) begin
        valj <= st_rdata;
      end
      if (cmd.j_inc) begin
        j <= j + IW'(1);
      end
      if (cmd.slot_inc) begin
        slot <= slot + IW'(1);
      end
      if (stk_we) begin
        sp <= sp + SPW'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.pop_ld) begin
        low  <= stk_lo;
        high <= stk_hi;
        slot <= stk_lo;
        j    <= stk_lo;
      end
      if (cmd.k_inc) begin
        k <= k + IW'(1);
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
        value_res <= VALUE_W'($signed(st_rdata));
        last_res  <= st.k_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
